FILE: src/fpa_pkg.sv
// Shared types and constants for the 16.16 fixed-point ALU.
package fpa_pkg;

   // Operand and result word width.
   localparam int WORD_WIDTH = 32;

   // Width of the operation code.
   localparam int OP_WIDTH = 3;

   // Operation codes.
   localparam logic [OP_WIDTH-1:0] OP_ADD  = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_ITOF = 3'd4;

   // Side information that travels with a transaction along the divider chain.
   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [WORD_WIDTH-1:0] result;
      logic                  overflow;
      logic                  div_zero;
      logic                  negative;
   } fpa_ctrl_type;

endpackage

FILE: src/fixed_point_alu_unit.sv
// Two input stages, one divider cell per quotient bit (32 + FRAC_BITS cells), one output stage.
// Throughput: one transaction per cycle for every operation; busy stays low.
// Every operation takes the same path, so results leave in the order transactions came in.
// Reset clears every stage's valid bit; data registers are not reset.
// The receiver cannot stall; each result is on the rsp_ ports for one cycle.
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [fpa_pkg::OP_WIDTH-1:0]          req_operation,
   input  logic signed [fpa_pkg::WORD_WIDTH-1:0] req_operand_a,
   input  logic signed [fpa_pkg::WORD_WIDTH-1:0] req_operand_b,
   output logic                                  rsp_valid,
   output logic signed [fpa_pkg::WORD_WIDTH-1:0] rsp_result,
   output logic                                  rsp_overflow,
   output logic                                  rsp_divide_by_zero
);

   localparam int W     = fpa_pkg::WORD_WIDTH;
   localparam int STEPS = W + FRAC_BITS;

   logic                  req_fire;
   logic                  chain_valid [STEPS+1];
   fpa_pkg::fpa_ctrl_type chain_ctrl  [STEPS+1];
   logic [W-1:0]          chain_rem   [STEPS+1];
   logic [STEPS-1:0]      chain_dq    [STEPS+1];
   logic [W-1:0]          chain_dvs   [STEPS+1];

   // The pipeline never stalls, so a transaction is taken whenever start is high.
   assign busy     = 1'b0;
   assign req_fire = start & ~busy;

   // Input stages.
   fpa_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .fire     (req_fire),
      .operation(req_operation),
      .operand_a(req_operand_a),
      .operand_b(req_operand_b),
      .valid    (chain_valid[0]),
      .ctrl     (chain_ctrl[0]),
      .dq       (chain_dq[0]),
      .divisor  (chain_dvs[0])
   );

   // The partial remainder starts at zero for every transaction.
   assign chain_rem[0] = '0;

   // Row of division cells, one quotient bit each.
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      fpa_div_cell #(
         .FRAC_BITS(FRAC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .valid_i  (chain_valid[i]),
         .ctrl_i   (chain_ctrl[i]),
         .rem_i    (chain_rem[i]),
         .dq_i     (chain_dq[i]),
         .divisor_i(chain_dvs[i]),
         .valid_o  (chain_valid[i+1]),
         .ctrl_o   (chain_ctrl[i+1]),
         .rem_o    (chain_rem[i+1]),
         .dq_o     (chain_dq[i+1]),
         .divisor_o(chain_dvs[i+1])
      );
   end

   // Output stage.
   fpa_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .valid             (chain_valid[STEPS]),
      .ctrl              (chain_ctrl[STEPS]),
      .quotient          (chain_dq[STEPS]),
      .rsp_valid         (rsp_valid),
      .rsp_result        (rsp_result),
      .rsp_overflow      (rsp_overflow),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

endmodule

FILE: src/fpa_front.sv
// Two input stages: multiplier and adder, then result fixup and divider setup.
module fpa_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     fire,
   input  logic [fpa_pkg::OP_WIDTH-1:0]             operation,
   input  logic signed [fpa_pkg::WORD_WIDTH-1:0]    operand_a,
   input  logic signed [fpa_pkg::WORD_WIDTH-1:0]    operand_b,
   output logic                                     valid,
   output fpa_pkg::fpa_ctrl_type                    ctrl,
   output logic [fpa_pkg::WORD_WIDTH+FRAC_BITS-1:0] dq,
   output logic [fpa_pkg::WORD_WIDTH-1:0]           divisor
);

   localparam int W      = fpa_pkg::WORD_WIDTH;
   localparam int QW     = W + FRAC_BITS;
   localparam int PW     = 2 * W;
   localparam int MUL_HI = PW - W + 1;
   localparam int ITF_HI = QW - W + 1;

   // Stage one registers.
   logic                 s1_valid_ff, s1_valid_in;
   logic [fpa_pkg::OP_WIDTH-1:0] s1_op_ff, s1_op_in;
   logic signed [PW-1:0] s1_prod_ff, s1_prod_in;
   logic signed [W:0]    s1_sum_ff, s1_sum_in;
   logic signed [W-1:0]  s1_a_ff, s1_a_in;
   logic signed [W-1:0]  s1_b_ff, s1_b_in;

   // Stage two registers.
   logic                  s2_valid_ff, s2_valid_in;
   fpa_pkg::fpa_ctrl_type s2_ctrl_ff, s2_ctrl_in;
   logic [QW-1:0]         s2_dq_ff, s2_dq_in;
   logic [W-1:0]          s2_dvs_ff, s2_dvs_in;

   logic signed [W:0]    a_ext;
   logic signed [W:0]    b_ext;
   logic signed [PW-1:0] mul_shift;
   logic [QW-1:0]        itof_wide;
   logic [W-1:0]         mag_a;
   logic [W-1:0]         mag_b;

   // Stage one: full product and 33-bit sum or difference.
   always_comb begin
      a_ext       = {operand_a[W-1], operand_a};
      b_ext       = {operand_b[W-1], operand_b};
      s1_valid_in = fire;
      s1_op_in    = operation;
      s1_prod_in  = operand_a * operand_b;
      s1_sum_in   = (operation == fpa_pkg::OP_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);
      s1_a_in     = operand_a;
      s1_b_in     = operand_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_op_ff   <= s1_op_in;
      s1_prod_ff <= s1_prod_in;
      s1_sum_ff  <= s1_sum_in;
      s1_a_ff    <= s1_a_in;
      s1_b_ff    <= s1_b_in;
   end

   // Stage two: scale and range-check the non-divide results, set up the divide.
   always_comb begin
      mul_shift = s1_prod_ff >>> FRAC_BITS;
      itof_wide = {s1_a_ff, {FRAC_BITS{1'b0}}};
      mag_a     = s1_a_ff[W-1] ? (~s1_a_ff + 1'b1) : s1_a_ff;
      mag_b     = s1_b_ff[W-1] ? (~s1_b_ff + 1'b1) : s1_b_ff;

      s2_valid_in         = s1_valid_ff;
      s2_ctrl_in.op       = s1_op_ff;
      s2_ctrl_in.result   = '0;
      s2_ctrl_in.overflow = 1'b0;
      s2_ctrl_in.div_zero = 1'b0;
      s2_ctrl_in.negative = s1_a_ff[W-1] ^ s1_b_ff[W-1];
      s2_dq_in            = {mag_a, {FRAC_BITS{1'b0}}};
      s2_dvs_in           = mag_b;

      case (s1_op_ff)
         fpa_pkg::OP_ADD, fpa_pkg::OP_SUB: begin
            s2_ctrl_in.result   = s1_sum_ff[W-1:0];
            s2_ctrl_in.overflow = s1_sum_ff[W] ^ s1_sum_ff[W-1];
         end
         fpa_pkg::OP_MUL: begin
            s2_ctrl_in.result   = mul_shift[W-1:0];
            s2_ctrl_in.overflow = (mul_shift[PW-1:W-1] != {MUL_HI{mul_shift[W-1]}});
         end
         fpa_pkg::OP_DIV: begin
            s2_ctrl_in.div_zero = (s1_b_ff == '0);
         end
         fpa_pkg::OP_ITOF: begin
            s2_ctrl_in.result   = itof_wide[W-1:0];
            s2_ctrl_in.overflow = (itof_wide[QW-1:W-1] != {ITF_HI{itof_wide[W-1]}});
         end
         default: begin
            s2_ctrl_in.result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      s2_ctrl_ff <= s2_ctrl_in;
      s2_dq_ff   <= s2_dq_in;
      s2_dvs_ff  <= s2_dvs_in;
   end

   assign valid   = s2_valid_ff;
   assign ctrl    = s2_ctrl_ff;
   assign dq      = s2_dq_ff;
   assign divisor = s2_dvs_ff;

endmodule

FILE: src/fpa_div_cell.sv
// One restoring-division cell: develops one quotient bit per transaction.
module fpa_div_cell #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     valid_i,
   input  fpa_pkg::fpa_ctrl_type                    ctrl_i,
   input  logic [fpa_pkg::WORD_WIDTH-1:0]           rem_i,
   input  logic [fpa_pkg::WORD_WIDTH+FRAC_BITS-1:0] dq_i,
   input  logic [fpa_pkg::WORD_WIDTH-1:0]           divisor_i,
   output logic                                     valid_o,
   output fpa_pkg::fpa_ctrl_type                    ctrl_o,
   output logic [fpa_pkg::WORD_WIDTH-1:0]           rem_o,
   output logic [fpa_pkg::WORD_WIDTH+FRAC_BITS-1:0] dq_o,
   output logic [fpa_pkg::WORD_WIDTH-1:0]           divisor_o
);

   localparam int W  = fpa_pkg::WORD_WIDTH;
   localparam int QW = W + FRAC_BITS;

   logic                  valid_ff, valid_in;
   fpa_pkg::fpa_ctrl_type ctrl_ff, ctrl_in;
   logic [W-1:0]          rem_ff, rem_in;
   logic [QW-1:0]         dq_ff, dq_in;
   logic [W-1:0]          dvs_ff, dvs_in;

   logic [W:0] partial;
   logic [W:0] diff;
   logic       fits;

   // Shift the next dividend bit into the remainder and try the subtraction.
   always_comb begin
      partial  = {rem_i, dq_i[QW-1]};
      diff     = partial - {1'b0, divisor_i};
      fits     = (partial >= {1'b0, divisor_i});
      valid_in = valid_i;
      ctrl_in  = ctrl_i;
      rem_in   = fits ? diff[W-1:0] : partial[W-1:0];
      dq_in    = {dq_i[QW-2:0], fits};
      dvs_in   = divisor_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ctrl_ff <= ctrl_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      dvs_ff  <= dvs_in;
   end

   assign valid_o   = valid_ff;
   assign ctrl_o    = ctrl_ff;
   assign rem_o     = rem_ff;
   assign dq_o      = dq_ff;
   assign divisor_o = dvs_ff;

endmodule

FILE: src/fpa_back.sv
// Output stage: signs the quotient, checks its range and selects the result.
module fpa_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     valid,
   input  fpa_pkg::fpa_ctrl_type                    ctrl,
   input  logic [fpa_pkg::WORD_WIDTH+FRAC_BITS-1:0] quotient,
   output logic                                     rsp_valid,
   output logic signed [fpa_pkg::WORD_WIDTH-1:0]    rsp_result,
   output logic                                     rsp_overflow,
   output logic                                     rsp_divide_by_zero
);

   localparam int W     = fpa_pkg::WORD_WIDTH;
   localparam int QW    = W + FRAC_BITS;
   localparam int SQ_HI = QW - W + 2;

   logic         valid_ff, valid_in;
   logic [W-1:0] result_ff, result_in;
   logic         ovf_ff, ovf_in;
   logic         dz_ff, dz_in;

   logic [QW:0] sq;

   // Apply the quotient sign, then pick the divide or the precomputed result.
   always_comb begin
      sq        = ctrl.negative ? (~{1'b0, quotient} + 1'b1) : {1'b0, quotient};
      valid_in  = valid;
      result_in = ctrl.result;
      ovf_in    = ctrl.overflow;
      dz_in     = 1'b0;
      if (ctrl.op == fpa_pkg::OP_DIV) begin
         if (ctrl.div_zero) begin
            result_in = '0;
            ovf_in    = 1'b0;
            dz_in     = 1'b1;
         end else begin
            result_in = sq[W-1:0];
            ovf_in    = (sq[QW:W-1] != {SQ_HI{sq[W-1]}});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
      ovf_ff    <= ovf_in;
      dz_ff     <= dz_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result         = result_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule
